// File: sv/hng_pkg.sv
// Shared constants, types and rounding helpers for the high-pass noise gate
package hng_pkg;
    localparam int SampleBits = 16;
    localparam int CoefBits   = 16;
    localparam int FiltBits   = SampleBits + 2;
    localparam int GainBits   = CoefBits + 1;
    localparam int ThrBits    = SampleBits - 1;
    localparam int AccBits    = 48;
    localparam int DivBits    = FiltBits + CoefBits;

    localparam logic [GainBits-1:0] OneQ      = GainBits'(1) << CoefBits;
    localparam int                  FloorInt  = ((12 * (1 << CoefBits)) + 50) / 100;
    localparam logic [GainBits-1:0] GateFloor = GainBits'(FloorInt);
    localparam logic [GainBits-1:0] GateSlope = OneQ - GateFloor;

    localparam logic signed [FiltBits-1:0] FiltMax = FiltBits'((1 << (SampleBits + 1)) - 1);
    localparam logic signed [FiltBits-1:0] FiltMin = -FiltBits'(1 << (SampleBits + 1));
    localparam logic signed [SampleBits-1:0] OutMax = SampleBits'((1 << (SampleBits - 1)) - 1);
    localparam logic signed [SampleBits-1:0] OutMin = -SampleBits'(1 << (SampleBits - 1));

    localparam logic [1:0] RegHp  = 2'd0;
    localparam logic [1:0] RegRel = 2'd1;
    localparam logic [1:0] RegSm  = 2'd2;
    localparam logic [1:0] RegThr = 2'd3;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_HP   = 7'b0000010,
        S_ENV  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_SQ   = 7'b0010000,
        S_GAIN = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic                       start;
        logic signed [AccBits-1:0]  a;
        logic signed [AccBits-1:0]  b;
    } t_mul_req;

    function automatic logic signed [AccBits-1:0] round_q(input logic signed [AccBits-1:0] p);
        round_q = (p + signed'(AccBits'(1) << (CoefBits - 1))) >>> CoefBits;
    endfunction
endpackage

// File: sv/hng_mul.sv
// Bit-serial shift-and-add signed multiplier, one multiplier bit per cycle
module hng_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  hng_pkg::t_mul_req                    i_req,
    output logic                                 o_done,
    output logic signed [hng_pkg::AccBits-1:0]   o_prod
);
    localparam int Cnt = hng_pkg::AccBits / 2;

    logic                                r_busy;
    logic [$clog2(Cnt+1)-1:0]            r_cnt;
    logic signed [hng_pkg::AccBits-1:0]  r_acc;
    logic signed [hng_pkg::AccBits-1:0]  r_mcand;
    logic [Cnt-1:0]                      r_mplier;
    logic                                r_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy   <= 1'b1;
            r_cnt    <= '0;
            r_acc    <= '0;
            r_neg    <= i_req.b[hng_pkg::AccBits-1];
            r_mcand  <= i_req.a;
            r_mplier <= i_req.b[hng_pkg::AccBits-1] ? Cnt'(-i_req.b) : Cnt'(i_req.b);
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand <<< 1;
            r_mplier <= r_mplier >> 1;
            r_cnt    <= r_cnt + 1'b1;
            if (r_cnt == ($clog2(Cnt+1))'(Cnt - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_busy && (r_cnt == ($clog2(Cnt+1))'(Cnt - 1));
    assign o_prod = r_neg ? -(r_acc + (r_mplier[0] ? r_mcand : '0))
                          :  (r_acc + (r_mplier[0] ? r_mcand : '0));
endmodule

// File: sv/hng_div.sv
// Restoring divider, one quotient bit per cycle, for the envelope ratio
module hng_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [hng_pkg::DivBits-1:0]         i_num,
    input  logic [hng_pkg::ThrBits-1:0]         i_den,
    output logic                                o_done,
    output logic [hng_pkg::DivBits-1:0]         o_quot
);
    localparam int CntW = $clog2(hng_pkg::DivBits + 1);

    logic                            r_busy;
    logic [CntW-1:0]                 r_cnt;
    logic [hng_pkg::DivBits-1:0]     r_q;
    logic [hng_pkg::ThrBits:0]       r_rem;
    logic [hng_pkg::ThrBits:0]       w_trial;

    assign w_trial = {r_rem[hng_pkg::ThrBits-1:0], r_q[hng_pkg::DivBits-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_q    <= i_num;
            r_rem  <= '0;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, i_den}) begin
                r_rem <= w_trial - {1'b0, i_den};
                r_q   <= {r_q[hng_pkg::DivBits-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_q   <= {r_q[hng_pkg::DivBits-2:0], 1'b0};
            end
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CntW'(hng_pkg::DivBits - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done = !r_busy && !i_start;
    assign o_quot = r_q;
endmodule

// File: sv/highpass_noise_gate_top.sv
// Top level of the high-pass noise gate: sequencer, state and output register
//
// channel   | handshake                  | payload
// input     | i_valid / o_ready          | i_sample_in, i_start_req
// result    | o_valid / i_ready          | o_sample_out
// config    | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// One item passes, from accept to next accept, through up to six products in the serial
// multiplier and, below the threshold, one ratio through the serial divider; attack skips
// the release product. Synchronous active-low reset clears control and filter state,
// sets the gain to unity and loads the default coefficients and threshold.
// A result waits in the output register; the next item is accepted meanwhile,
// and the last product repeats until that register is free.
module highpass_noise_gate_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [15:0]    i_sample_in,
    input  logic                  i_start_req,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [15:0]    o_sample_out,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [15:0]           i_cfg_data
);
    localparam int A = hng_pkg::AccBits;
    localparam int F = hng_pkg::FiltBits;
    localparam int G = hng_pkg::GainBits;

    hng_pkg::t_state r_state;
    logic            r_sub;

    logic [15:0]               r_hp_coef, r_rel_coef, r_sm_coef;
    logic [14:0]               r_thr;
    logic signed [15:0]        r_x, r_last_in;
    logic signed [F-1:0]       r_last_filt, r_y;
    logic [F-1:0]              r_env, r_mag;
    logic [G-1:0]              r_gain, r_target;
    logic signed [A-1:0]       r_tmp;
    logic                      r_mul_busy, r_div_go, r_out_v;
    logic signed [15:0]        r_out;

    hng_pkg::t_mul_req         w_req;
    logic                      w_mdone, w_ddone, w_gate_open;
    logic signed [A-1:0]       w_prod, w_rq, w_hp_v, w_gain_v;
    logic signed [F-1:0]       w_y;
    logic [hng_pkg::DivBits-1:0] w_quot;

    hng_mul u_mul (.i_clk, .i_rst_n, .i_req(w_req), .o_done(w_mdone), .o_prod(w_prod));
    hng_div u_div (.i_clk, .i_rst_n, .i_start(r_div_go),
                   .i_num({r_env, hng_pkg::CoefBits'(0)}), .i_den(r_thr),
                   .o_done(w_ddone), .o_quot(w_quot));

    assign w_rq    = hng_pkg::round_q(w_prod);
    assign o_ready = i_rst_n && (r_state == hng_pkg::S_IDLE);
    assign o_valid = r_out_v;
    assign o_sample_out = r_out;

    assign w_gate_open = A'({1'b0, r_env}) >= A'({1'b0, r_thr});
    assign w_hp_v      = A'(r_x) - A'(r_last_in) + w_rq;
    assign w_gain_v    = A'(signed'({1'b0, r_target})) + w_rq;

    always_comb begin
        if (w_hp_v > A'(hng_pkg::FiltMax)) begin
            w_y = hng_pkg::FiltMax;
        end else if (w_hp_v < A'(hng_pkg::FiltMin)) begin
            w_y = hng_pkg::FiltMin;
        end else begin
            w_y = F'(w_hp_v);
        end
    end

    always_comb begin
        w_req.start = 1'b0;
        w_req.a     = '0;
        w_req.b     = '0;
        if (!r_mul_busy) begin
            unique case (r_state)
                hng_pkg::S_HP: begin
                    w_req.start = 1'b1;
                    w_req.a = A'(r_last_filt);
                    w_req.b = A'({1'b0, r_hp_coef});
                end
                hng_pkg::S_ENV: begin
                    w_req.start = (r_mag <= r_env);
                    w_req.a = A'(signed'({1'b0, r_env}) - signed'({1'b0, r_mag}));
                    w_req.b = A'({1'b0, r_rel_coef});
                end
                hng_pkg::S_SQ: begin
                    w_req.start = 1'b1;
                    w_req.a = r_sub ? r_tmp : A'({1'b0, w_quot});
                    w_req.b = r_sub ? A'({1'b0, hng_pkg::GateSlope}) : A'({1'b0, w_quot});
                end
                hng_pkg::S_GAIN: begin
                    w_req.start = 1'b1;
                    w_req.a = A'(signed'({1'b0, r_gain})) - A'(signed'({1'b0, r_target}));
                    w_req.b = A'({1'b0, r_sm_coef});
                end
                hng_pkg::S_OUT: begin
                    w_req.start = 1'b1;
                    w_req.a = A'(r_y);
                    w_req.b = A'({1'b0, r_gain});
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hng_pkg::S_IDLE;
            r_sub       <= 1'b0;
            r_mul_busy  <= 1'b0;
            r_div_go    <= 1'b0;
            r_out_v     <= 1'b0;
            r_hp_coef   <= 16'd64585;
            r_rel_coef  <= 16'd65519;
            r_sm_coef   <= 16'd65422;
            r_thr       <= 15'd58;
            r_last_in   <= '0;
            r_last_filt <= '0;
            r_env       <= '0;
            r_gain      <= hng_pkg::OneQ;
        end else begin
            r_div_go <= (r_state == hng_pkg::S_DIV) && r_sub && !w_gate_open;
            if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    hng_pkg::RegHp:  r_hp_coef  <= i_cfg_data;
                    hng_pkg::RegRel: r_rel_coef <= i_cfg_data;
                    hng_pkg::RegSm:  r_sm_coef  <= i_cfg_data;
                    hng_pkg::RegThr: r_thr      <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (w_req.start) begin
                r_mul_busy <= 1'b1;
            end
            if (w_mdone) begin
                r_mul_busy <= 1'b0;
            end
            unique case (r_state)
                hng_pkg::S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_x   <= i_sample_in;
                        r_sub <= 1'b0;
                        if (i_start_req) begin
                            r_last_in   <= '0;
                            r_last_filt <= '0;
                            r_env       <= '0;
                            r_gain      <= hng_pkg::OneQ;
                        end
                        r_state <= hng_pkg::S_HP;
                    end
                end
                hng_pkg::S_HP: begin
                    if (w_mdone) begin
                        r_y         <= w_y;
                        r_last_in   <= r_x;
                        r_last_filt <= w_y;
                        r_mag       <= w_y[F-1] ? F'(-w_y) : F'(w_y);
                        r_state     <= hng_pkg::S_ENV;
                    end
                end
                hng_pkg::S_ENV: begin
                    if (r_mag > r_env) begin
                        r_env      <= r_mag;
                        r_state    <= hng_pkg::S_DIV;
                        r_sub      <= 1'b1;
                    end else if (w_mdone) begin
                        r_env   <= F'(A'({1'b0, r_mag}) + w_rq);
                        r_state <= hng_pkg::S_DIV;
                        r_sub   <= 1'b1;
                    end
                end
                hng_pkg::S_DIV: begin
                    if (r_sub) begin
                        r_sub <= 1'b0;
                        if (w_gate_open) begin
                            r_target <= hng_pkg::OneQ;
                            r_state  <= hng_pkg::S_GAIN;
                        end
                    end else if (!r_div_go && w_ddone) begin
                        r_state <= hng_pkg::S_SQ;
                    end
                end
                hng_pkg::S_SQ: begin
                    if (w_mdone) begin
                        if (!r_sub) begin
                            r_tmp <= w_rq;
                            r_sub <= 1'b1;
                        end else begin
                            r_target <= G'(A'({1'b0, hng_pkg::GateFloor}) + w_rq);
                            r_sub    <= 1'b0;
                            r_state  <= hng_pkg::S_GAIN;
                        end
                    end
                end
                hng_pkg::S_GAIN: begin
                    if (w_mdone) begin
                        if (w_gain_v < 0) begin
                            r_gain <= '0;
                        end else if (w_gain_v > A'({1'b0, hng_pkg::OneQ})) begin
                            r_gain <= hng_pkg::OneQ;
                        end else begin
                            r_gain <= G'(w_gain_v);
                        end
                        r_state <= hng_pkg::S_OUT;
                    end
                end
                hng_pkg::S_OUT: begin
                    if (w_mdone && !r_out_v) begin
                        if (w_rq > A'(hng_pkg::OutMax)) begin
                            r_out <= hng_pkg::OutMax;
                        end else if (w_rq < A'(hng_pkg::OutMin)) begin
                            r_out <= hng_pkg::OutMin;
                        end else begin
                            r_out <= 16'(w_rq);
                        end
                        r_out_v <= 1'b1;
                        r_state <= hng_pkg::S_IDLE;
                    end
                end
                default: r_state <= hng_pkg::S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= hng_pkg::OneQ) else $error("gain above unity");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != hng_pkg::S_IDLE) |-> !o_ready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_sample_out)))
        else $error("result dropped");
`endif
endmodule
